FILE: rtl/core/tss_pkg.sv
// Shared types, constants and arithmetic helpers for the triangle scanline span pipeline.
package tss_pkg;

  // Coordinate width of every vertex, row and span field.
  localparam int CoordBits = 12;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] ucoord_t;
  typedef logic signed [CoordBits:0]   delta_t;
  typedef logic signed [2*CoordBits+1:0] prod_t;

  // Input item: three vertices and the row offset.
  typedef struct packed {
    coord_t  vertex0_x;
    coord_t  vertex0_y;
    coord_t  vertex1_x;
    coord_t  vertex1_y;
    coord_t  vertex2_x;
    coord_t  vertex2_y;
    ucoord_t row_index;
  } req_t;

  // Result item: the span of one row.
  typedef struct packed {
    logic    span_valid;
    coord_t  span_y;
    coord_t  span_left;
    coord_t  span_right;
    ucoord_t row_count;
  } rsp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  // Vertices after sorting by ascending y.
  typedef struct packed {
    vtx_t    top;
    vtx_t    mid;
    vtx_t    bot;
    ucoord_t row;
  } sorted_t;

  // Fields that ride along with an item to the end of the pipeline.
  typedef struct packed {
    logic    valid;
    coord_t  y;
    ucoord_t row_count;
  } info_t;

  // One edge before the multiply.
  typedef struct packed {
    coord_t  start;
    delta_t  delta;
    ucoord_t num;
    ucoord_t h;
  } edge_setup_t;

  typedef struct packed {
    info_t       info;
    edge_setup_t edge_a;
    edge_setup_t edge_b;
  } setup_item_t;

  // One edge after the multiply.
  typedef struct packed {
    coord_t  start;
    prod_t   prod;
    ucoord_t h;
  } edge_prod_t;

  typedef struct packed {
    info_t      info;
    edge_prod_t edge_a;
    edge_prod_t edge_b;
  } prod_item_t;

  // One edge inside the divider: partial remainder r, and l which holds the
  // unused dividend bits on top and the quotient bits shifted in below.
  typedef struct packed {
    coord_t  start;
    logic    neg;
    ucoord_t h;
    ucoord_t r;
    ucoord_t l;
  } edge_div_t;

  typedef struct packed {
    info_t     info;
    edge_div_t edge_a;
    edge_div_t edge_b;
  } div_item_t;

  // Both edge x values of one row.
  typedef struct packed {
    info_t  info;
    coord_t ax;
    coord_t bx;
  } xs_item_t;

  // Sign extension by one bit.
  function automatic delta_t ext1(input coord_t v);
    return {v[CoordBits-1], v};
  endfunction

  // One restoring division step: produces one quotient bit.
  function automatic edge_div_t div_step(input edge_div_t e);
    logic [CoordBits:0] trial;
    logic [CoordBits:0] diff;
    edge_div_t          n;
    n     = e;
    trial = {e.r, e.l[CoordBits-1]};
    diff  = trial - {1'b0, e.h};
    if (trial >= {1'b0, e.h}) begin
      n.r = diff[CoordBits-1:0];
      n.l = {e.l[CoordBits-2:0], 1'b1};
    end else begin
      n.r = trial[CoordBits-1:0];
      n.l = {e.l[CoordBits-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/tss_setup.sv
// Front of the pipeline: vertex sort, edge setup, multiply and sign split.
module tss_setup (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  tss_pkg::req_t      up_item,
  output logic               dn_valid,
  input  logic               dn_stall,
  output tss_pkg::div_item_t dn_item
);
  import tss_pkg::*;

  // Stage registers and their valid bits.
  sorted_t     sorted;
  logic        sorted_valid;
  setup_item_t edges;
  logic        edges_valid;
  prod_item_t  prods;
  logic        prods_valid;
  div_item_t   split;
  logic        split_valid;

  logic sorted_hold, edges_hold, prods_hold, split_hold;

  sorted_t     sorted_next;
  setup_item_t edges_next;
  prod_item_t  prods_next;
  div_item_t   split_next;

  // A stage holds only when it carries an item and the next one holds.
  assign split_hold  = split_valid && dn_stall;
  assign prods_hold  = prods_valid && split_hold;
  assign edges_hold  = edges_valid && prods_hold;
  assign sorted_hold = sorted_valid && edges_hold;
  assign up_stall    = sorted_hold;
  assign dn_valid    = split_valid;
  assign dn_item     = split;

  // Three compare-and-swap steps; a swap happens only on a strictly greater y.
  vtx_t v0, v1, v2, t01, t02, t12;
  always_comb begin
    v0 = '{x: up_item.vertex0_x, y: up_item.vertex0_y};
    v1 = '{x: up_item.vertex1_x, y: up_item.vertex1_y};
    v2 = '{x: up_item.vertex2_x, y: up_item.vertex2_y};
    t01 = v0;
    t12 = v1;
    if (v0.y > v1.y) begin
      t01 = v1;
      t12 = v0;
    end
    t02 = v2;
    sorted_next.top = t01;
    if (t01.y > v2.y) begin
      sorted_next.top = v2;
      t02 = t01;
    end
    sorted_next.mid = t12;
    sorted_next.bot = t02;
    if (t12.y > t02.y) begin
      sorted_next.mid = t02;
      sorted_next.bot = t12;
    end
    sorted_next.row = up_item.row_index;
  end

  // Heights, half selection and both edges to interpolate.
  delta_t  total_w, first_w, rest_w;
  ucoord_t total, first_h, rest_h;
  logic    second;
  always_comb begin
    total_w = ext1(sorted.bot.y) - ext1(sorted.top.y);
    first_w = ext1(sorted.mid.y) - ext1(sorted.top.y);
    rest_w  = ext1(sorted.bot.y) - ext1(sorted.mid.y);
    total   = total_w[CoordBits-1:0];
    first_h = first_w[CoordBits-1:0];
    rest_h  = rest_w[CoordBits-1:0];
    second  = (sorted.row > first_h) || (first_h == '0);

    edges_next.info.valid     = sorted.row < total;
    edges_next.info.y         = coord_t'(sorted.top.y + signed'(sorted.row));
    edges_next.info.row_count = total;

    edges_next.edge_a.start = sorted.top.x;
    edges_next.edge_a.delta = ext1(sorted.bot.x) - ext1(sorted.top.x);
    edges_next.edge_a.num   = sorted.row;
    edges_next.edge_a.h     = total;

    if (second) begin
      edges_next.edge_b.start = sorted.mid.x;
      edges_next.edge_b.delta = ext1(sorted.bot.x) - ext1(sorted.mid.x);
      edges_next.edge_b.num   = sorted.row - first_h;
      edges_next.edge_b.h     = rest_h;
    end else begin
      edges_next.edge_b.start = sorted.top.x;
      edges_next.edge_b.delta = ext1(sorted.mid.x) - ext1(sorted.top.x);
      edges_next.edge_b.num   = sorted.row;
      edges_next.edge_b.h     = first_h;
    end
  end

  // Delta times numerator for both edges.
  always_comb begin
    prods_next.info         = edges.info;
    prods_next.edge_a.start = edges.edge_a.start;
    prods_next.edge_a.h     = edges.edge_a.h;
    prods_next.edge_a.prod  = prod_t'(edges.edge_a.delta) * prod_t'(signed'({1'b0, edges.edge_a.num}));
    prods_next.edge_b.start = edges.edge_b.start;
    prods_next.edge_b.h     = edges.edge_b.h;
    prods_next.edge_b.prod  = prod_t'(edges.edge_b.delta) * prod_t'(signed'({1'b0, edges.edge_b.num}));
  end

  // Split each product into sign and magnitude for the unsigned divider.
  prod_t mag_a, mag_b;
  always_comb begin
    mag_a = prods.edge_a.prod[2*CoordBits+1] ? -prods.edge_a.prod : prods.edge_a.prod;
    mag_b = prods.edge_b.prod[2*CoordBits+1] ? -prods.edge_b.prod : prods.edge_b.prod;
    split_next.info         = prods.info;
    split_next.edge_a.start = prods.edge_a.start;
    split_next.edge_a.neg   = prods.edge_a.prod[2*CoordBits+1];
    split_next.edge_a.h     = prods.edge_a.h;
    split_next.edge_a.r     = mag_a[2*CoordBits-1:CoordBits];
    split_next.edge_a.l     = mag_a[CoordBits-1:0];
    split_next.edge_b.start = prods.edge_b.start;
    split_next.edge_b.neg   = prods.edge_b.prod[2*CoordBits+1];
    split_next.edge_b.h     = prods.edge_b.h;
    split_next.edge_b.r     = mag_b[2*CoordBits-1:CoordBits];
    split_next.edge_b.l     = mag_b[CoordBits-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
      edges_valid  <= 1'b0;
      prods_valid  <= 1'b0;
      split_valid  <= 1'b0;
    end else begin
      if (!sorted_hold) sorted_valid <= up_valid;
      if (!edges_hold)  edges_valid  <= sorted_valid;
      if (!prods_hold)  prods_valid  <= edges_valid;
      if (!split_hold)  split_valid  <= prods_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!sorted_hold) sorted <= sorted_next;
    if (!edges_hold)  edges  <= edges_next;
    if (!prods_hold)  prods  <= prods_next;
    if (!split_hold)  split  <= split_next;
  end

endmodule

FILE: rtl/core/tss_div.sv
// Pipelined restoring divider: one quotient bit per stage for both edges.
module tss_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  tss_pkg::div_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_stall,
  output tss_pkg::div_item_t dn_item
);
  import tss_pkg::*;

  div_item_t            stage [CoordBits];
  div_item_t            src   [CoordBits];
  logic [CoordBits-1:0] vld;
  logic [CoordBits-1:0] src_valid;
  logic [CoordBits:0]   hold;

  // Each stage feeds from the one before it, the first from the input.
  always_comb begin
    src[0] = up_item;
    for (int k = 1; k < CoordBits; k++) begin
      src[k] = stage[k-1];
    end
  end
  assign src_valid = {vld[CoordBits-2:0], up_valid};

  // Hold chain from the output back to the input.
  assign hold[CoordBits] = dn_stall;
  assign hold[CoordBits-1:0] = vld & hold[CoordBits:1];

  assign up_stall = hold[0];
  assign dn_valid = vld[CoordBits-1];
  assign dn_item  = stage[CoordBits-1];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < CoordBits; k++) begin
        if (!hold[k]) vld[k] <= src_valid[k];
      end
    end
  end

  // One division step per stage.
  always_ff @(posedge clk) begin
    for (int k = 0; k < CoordBits; k++) begin
      if (!hold[k]) begin
        stage[k].info   <= src[k].info;
        stage[k].edge_a <= div_step(src[k].edge_a);
        stage[k].edge_b <= div_step(src[k].edge_b);
      end
    end
  end

endmodule

FILE: rtl/core/tss_finish.sv
// Back of the pipeline: edge x from quotient, left/right order and result register.
module tss_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  tss_pkg::div_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_stall,
  output tss_pkg::rsp_t      dn_item
);
  import tss_pkg::*;

  xs_item_t xs;
  logic     xs_valid;
  rsp_t     result;
  logic     result_valid;
  logic     xs_hold, result_hold;

  xs_item_t xs_next;
  rsp_t     result_next;
  delta_t   qa, qb, sum_a, sum_b;

  assign result_hold = result_valid && dn_stall;
  assign xs_hold     = xs_valid && result_hold;
  assign up_stall    = xs_hold;
  assign dn_valid    = result_valid;
  assign dn_item     = result;

  // Edge x is the start plus the signed quotient.
  always_comb begin
    qa = up_item.edge_a.neg ? -delta_t'({1'b0, up_item.edge_a.l})
                            : delta_t'({1'b0, up_item.edge_a.l});
    qb = up_item.edge_b.neg ? -delta_t'({1'b0, up_item.edge_b.l})
                            : delta_t'({1'b0, up_item.edge_b.l});
    sum_a = ext1(up_item.edge_a.start) + qa;
    sum_b = ext1(up_item.edge_b.start) + qb;
    xs_next.info = up_item.info;
    xs_next.ax   = sum_a[CoordBits-1:0];
    xs_next.bx   = sum_b[CoordBits-1:0];
  end

  // Order both edges; an invalid row reports zeros besides the row count.
  always_comb begin
    result_next.span_valid = xs.info.valid;
    result_next.row_count  = xs.info.row_count;
    result_next.span_y     = '0;
    result_next.span_left  = '0;
    result_next.span_right = '0;
    if (xs.info.valid) begin
      result_next.span_y = xs.info.y;
      if (xs.ax > xs.bx) begin
        result_next.span_left  = xs.bx;
        result_next.span_right = xs.ax;
      end else begin
        result_next.span_left  = xs.ax;
        result_next.span_right = xs.bx;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      xs_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!xs_hold)     xs_valid     <= up_valid;
      if (!result_hold) result_valid <= xs_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!xs_hold)     xs     <= xs_next;
    if (!result_hold) result <= result_next;
  end

endmodule

FILE: rtl/core/triangle_scanline_span.sv
// Top level of the triangle scanline span pipeline.
//
//   channel | ports                          | carries
//   --------+--------------------------------+-------------------------------
//   request | req_valid, req_stall, req      | three vertices and a row index
//   result  | rsp_valid, rsp_stall, rsp      | span y, left, right, row count
//
// One item enters per cycle while req_stall is low; the divider resolves one
// quotient bit per stage.
// Reset clears only the valid bits of the stages; payload registers are not reset.
// A stalled result holds only the stages behind it that carry items, so empty
// stages still fill while the output waits.
module triangle_scanline_span (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tss_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tss_pkg::rsp_t  rsp
);
  import tss_pkg::*;

  logic      setup_valid, setup_stall;
  div_item_t setup_item;
  logic      div_valid, div_stall;
  div_item_t div_item;

  // Sort, edge setup, multiply and sign split.
  tss_setup u_setup (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_stall (req_stall),
    .up_item  (req),
    .dn_valid (setup_valid),
    .dn_stall (setup_stall),
    .dn_item  (setup_item)
  );

  // Edge division.
  tss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (setup_valid),
    .up_stall (setup_stall),
    .up_item  (setup_item),
    .dn_valid (div_valid),
    .dn_stall (div_stall),
    .dn_item  (div_item)
  );

  // Edge x, ordering and result register.
  tss_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .up_valid (div_valid),
    .up_stall (div_stall),
    .up_item  (div_item),
    .dn_valid (rsp_valid),
    .dn_stall (rsp_stall),
    .dn_item  (rsp)
  );

endmodule
